// ===== hdl/srtf_pkg.sv =====
// Shared types and constants for the SRTF waiting-time block.
// Used by the sequencer, the entry memory, the result register and the top level.
// No dependencies.
`default_nettype none

package srtf_pkg;

  localparam int SlotLimit       = 64;
  localparam int MaxProcessesDef = 64;
  localparam int TimeBitsDef     = 16;

  localparam int TimeW  = 16;
  localparam int BestW  = 17;
  localparam int ClkW   = 24;
  localparam int WaitW  = 23;
  localparam int TotalW = 29;
  localparam int PnumW  = 7;

  typedef enum logic [2:0] {
    StIdle,
    StIter,
    StScan,
    StDecide,
    StRetire,
    StOutRd,
    StOutLd
  } seq_state_e;

  typedef struct packed {
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
  } tbl_word_t;

  typedef struct packed {
    logic [TimeW-1:0] remaining;
    logic [WaitW-1:0] waiting;
  } dyn_word_t;

  typedef struct packed {
    logic tbl;
    logic dyn;
    logic rd;
  } mem_ctl_t;

  typedef struct packed {
    logic [PnumW-1:0]  process_number;
    logic [WaitW-1:0]  waiting_time;
    logic [WaitW-1:0]  turnaround;
    logic [TotalW-1:0] total_waiting;
    logic [TotalW-1:0] total_turnaround;
    logic              overflow;
    logic              final_result;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/srtf_mem.sv =====
// Process table: static entry memory (arrival, burst) and dynamic memory
// (remaining, waiting), one write port and one registered read port each.
// Depends on srtf_pkg.
`default_nettype none

module srtf_mem #(
  parameter int Depth = srtf_pkg::MaxProcessesDef,
  parameter int IdxW  = 6
) (
  input  wire logic                clk_i,
  input  wire srtf_pkg::mem_ctl_t  ctl_i,
  input  wire logic [IdxW-1:0]     waddr_i,
  input  wire srtf_pkg::tbl_word_t tbl_wdata_i,
  input  wire srtf_pkg::dyn_word_t dyn_wdata_i,
  input  wire logic [IdxW-1:0]     raddr_i,
  output srtf_pkg::tbl_word_t      tbl_rdata_o,
  output srtf_pkg::dyn_word_t      dyn_rdata_o
);

  srtf_pkg::tbl_word_t tbl_mem [Depth];
  srtf_pkg::dyn_word_t dyn_mem [Depth];
  srtf_pkg::tbl_word_t tbl_rdata_q;
  srtf_pkg::dyn_word_t dyn_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.tbl) begin
      tbl_mem[waddr_i] <= tbl_wdata_i;
    end
    if (ctl_i.dyn) begin
      dyn_mem[waddr_i] <= dyn_wdata_i;
    end
    if (ctl_i.rd) begin
      tbl_rdata_q <= tbl_mem[raddr_i];
      dyn_rdata_q <= dyn_mem[raddr_i];
    end
  end

  assign tbl_rdata_o = tbl_rdata_q;
  assign dyn_rdata_o = dyn_rdata_q;

endmodule

`default_nettype wire

// ===== hdl/srtf_seq.sv =====
// Sequencer: loads entries, runs the SRTF simulation over the process table
// by repeated memory scans, then reads out one result per process.
// Depends on srtf_pkg; drives srtf_mem and the result register.
`default_nettype none

module srtf_seq #(
  parameter int MAX_PROCESSES = srtf_pkg::MaxProcessesDef,
  parameter int TIME_BITS     = srtf_pkg::TimeBitsDef,
  parameter int IdxW          = 6,
  parameter int CntW          = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [srtf_pkg::TimeW-1:0]    arrival_time_i,
  input  wire logic [srtf_pkg::TimeW-1:0]    burst_time_i,
  input  wire logic                          final_entry_i,
  output srtf_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [IdxW-1:0]                    mem_waddr_o,
  output srtf_pkg::tbl_word_t                tbl_wdata_o,
  output srtf_pkg::dyn_word_t                dyn_wdata_o,
  output logic [IdxW-1:0]                    mem_raddr_o,
  input  wire srtf_pkg::tbl_word_t           tbl_rdata_i,
  input  wire srtf_pkg::dyn_word_t           dyn_rdata_i,
  input  wire logic                          res_free_i,
  output logic                               res_load_o,
  output srtf_pkg::result_t                  res_o
);

  localparam int TimeW  = srtf_pkg::TimeW;
  localparam int BestW  = srtf_pkg::BestW;
  localparam int ClkW   = srtf_pkg::ClkW;
  localparam int WaitW  = srtf_pkg::WaitW;
  localparam int TotalW = srtf_pkg::TotalW;
  localparam int PnumW  = srtf_pkg::PnumW;
  localparam logic [TimeW-1:0] TimeMask = (TIME_BITS >= TimeW) ? {TimeW{1'b1}} :
                                          TimeW'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [CntW-1:0] Capacity = CntW'(MAX_PROCESSES);

  srtf_pkg::seq_state_e state_q, state_d;

  logic [CntW-1:0]   entry_cnt_q, done_cnt_q, rd_cnt_q, out_idx_q;
  logic              dropped_q, have_choice_q, have_next_q, eval_vld_q;
  logic [ClkW-1:0]   clk_q;
  logic [IdxW-1:0]   chosen_q, eval_idx_q;
  logic [BestW-1:0]  best_q;
  logic [TimeW-1:0]  chosen_arr_q, chosen_burst_q, next_q;
  logic [TotalW-1:0] tw_q, tt_q;

  logic              in_acc;
  logic [TimeW-1:0]  arr_m, bur_m;
  logic              room;
  logic              scan_rd, scan_last;
  logic              cand_run, cand_next;
  logic [TimeW-1:0]  gap;
  logic              preempt;
  logic [TimeW-1:0]  rem_new;
  logic [BestW-1:0]  used;
  logic [ClkW-1:0]   wait_full;
  logic [ClkW-1:0]   turn_full;
  logic              out_last;

  assign arr_m     = arrival_time_i & TimeMask;
  assign bur_m     = burst_time_i & TimeMask;
  assign room      = entry_cnt_q < Capacity;
  assign in_acc    = in_valid_i && in_ready_o;
  assign scan_rd   = rd_cnt_q < entry_cnt_q;
  assign scan_last = !scan_rd && eval_vld_q;

  assign cand_run  = eval_vld_q && (dyn_rdata_i.remaining != '0) &&
                     (ClkW'(tbl_rdata_i.arrival) <= clk_q) &&
                     ({1'b0, dyn_rdata_i.remaining} < best_q);
  assign cand_next = eval_vld_q && (dyn_rdata_i.remaining != '0) &&
                     (ClkW'(tbl_rdata_i.arrival) > clk_q) &&
                     (!have_next_q || (tbl_rdata_i.arrival < next_q));

  assign gap       = TimeW'(ClkW'(next_q) - clk_q);
  assign preempt   = have_next_q && ({1'b0, gap} < best_q);
  assign rem_new   = TimeW'(best_q - BestW'(gap));
  assign used      = BestW'(chosen_arr_q) + BestW'(chosen_burst_q);
  assign wait_full = (clk_q > ClkW'(used)) ? (clk_q - ClkW'(used)) : '0;
  assign turn_full = ClkW'(tbl_rdata_i.burst) + ClkW'(dyn_rdata_i.waiting);
  assign out_last  = (out_idx_q + CntW'(1)) == entry_cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      srtf_pkg::StIdle: begin
        if (in_acc && final_entry_i) begin
          state_d = srtf_pkg::StIter;
        end
      end
      srtf_pkg::StIter: begin
        state_d = (done_cnt_q == entry_cnt_q) ? srtf_pkg::StOutRd : srtf_pkg::StScan;
      end
      srtf_pkg::StScan: begin
        if (scan_last) begin
          state_d = srtf_pkg::StDecide;
        end
      end
      srtf_pkg::StDecide: begin
        if (!have_choice_q) begin
          state_d = have_next_q ? srtf_pkg::StIter : srtf_pkg::StOutRd;
        end else begin
          state_d = preempt ? srtf_pkg::StIter : srtf_pkg::StRetire;
        end
      end
      srtf_pkg::StRetire: state_d = srtf_pkg::StIter;
      srtf_pkg::StOutRd:  state_d = srtf_pkg::StOutLd;
      srtf_pkg::StOutLd: begin
        if (res_free_i) begin
          state_d = out_last ? srtf_pkg::StIdle : srtf_pkg::StOutRd;
        end
      end
      default: state_d = srtf_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_ctl_o   = '0;
    mem_waddr_o = chosen_q;
    mem_raddr_o = out_idx_q[IdxW-1:0];
    tbl_wdata_o = '{arrival: arr_m, burst: bur_m};
    dyn_wdata_o = '{remaining: '0, waiting: WaitW'(wait_full)};
    res_load_o  = 1'b0;
    case (state_q)
      srtf_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        mem_ctl_o.tbl = in_valid_i && room;
        mem_ctl_o.dyn = in_valid_i && room;
        mem_waddr_o   = entry_cnt_q[IdxW-1:0];
        dyn_wdata_o   = '{remaining: bur_m, waiting: '0};
      end
      srtf_pkg::StScan: begin
        mem_ctl_o.rd = scan_rd;
        mem_raddr_o  = rd_cnt_q[IdxW-1:0];
      end
      srtf_pkg::StDecide: begin
        mem_ctl_o.dyn = have_choice_q && preempt;
        dyn_wdata_o   = '{remaining: rem_new, waiting: '0};
      end
      srtf_pkg::StRetire: mem_ctl_o.dyn = 1'b1;
      srtf_pkg::StOutRd:  mem_ctl_o.rd = 1'b1;
      srtf_pkg::StOutLd:  res_load_o = res_free_i;
      default: ;
    endcase
  end

  always_comb begin
    res_o.process_number   = PnumW'(out_idx_q + CntW'(1));
    res_o.waiting_time     = dyn_rdata_i.waiting;
    res_o.turnaround       = WaitW'(turn_full);
    res_o.total_waiting    = out_last ? (tw_q + TotalW'(dyn_rdata_i.waiting)) : '0;
    res_o.total_turnaround = out_last ? (tt_q + TotalW'(turn_full)) : '0;
    res_o.overflow         = dropped_q;
    res_o.final_result     = out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srtf_pkg::StIdle;
      entry_cnt_q   <= '0;
      done_cnt_q    <= '0;
      dropped_q     <= 1'b0;
      clk_q         <= '0;
      chosen_q      <= '0;
      best_q        <= '1;
      have_choice_q <= 1'b0;
      have_next_q   <= 1'b0;
      eval_vld_q    <= 1'b0;
      rd_cnt_q      <= '0;
      out_idx_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        srtf_pkg::StIdle: begin
          if (in_acc) begin
            if (room) begin
              entry_cnt_q <= entry_cnt_q + CntW'(1);
              if (bur_m == '0) begin
                done_cnt_q <= done_cnt_q + CntW'(1);
              end
            end else begin
              dropped_q <= 1'b1;
            end
            if (final_entry_i) begin
              clk_q         <= '0;
              chosen_q      <= '0;
              best_q        <= '1;
              have_choice_q <= 1'b0;
            end
          end
        end
        srtf_pkg::StIter: begin
          rd_cnt_q    <= '0;
          eval_vld_q  <= 1'b0;
          have_next_q <= 1'b0;
          out_idx_q   <= '0;
          if (!have_choice_q) begin
            best_q <= '1;
          end
        end
        srtf_pkg::StScan: begin
          eval_vld_q <= scan_rd;
          if (scan_rd) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          if (cand_run) begin
            best_q        <= {1'b0, dyn_rdata_i.remaining};
            chosen_q      <= eval_idx_q;
            have_choice_q <= 1'b1;
          end
          if (cand_next) begin
            next_q      <= tbl_rdata_i.arrival;
            have_next_q <= 1'b1;
          end
        end
        srtf_pkg::StDecide: begin
          out_idx_q <= '0;
          if (!have_choice_q) begin
            clk_q <= ClkW'(next_q);
          end else if (preempt) begin
            clk_q  <= ClkW'(next_q);
            best_q <= {1'b0, rem_new};
          end else begin
            clk_q <= clk_q + ClkW'(best_q);
          end
        end
        srtf_pkg::StRetire: begin
          done_cnt_q    <= done_cnt_q + CntW'(1);
          have_choice_q <= 1'b0;
          best_q        <= '1;
        end
        srtf_pkg::StOutLd: begin
          if (res_free_i) begin
            out_idx_q <= out_idx_q + CntW'(1);
            if (out_last) begin
              entry_cnt_q <= '0;
              done_cnt_q  <= '0;
              dropped_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      srtf_pkg::StScan: begin
        eval_idx_q <= rd_cnt_q[IdxW-1:0];
        if (cand_run) begin
          chosen_arr_q   <= tbl_rdata_i.arrival;
          chosen_burst_q <= tbl_rdata_i.burst;
        end
      end
      srtf_pkg::StIter: begin
        tw_q <= '0;
        tt_q <= '0;
      end
      srtf_pkg::StOutLd: begin
        if (res_free_i) begin
          tw_q <= tw_q + TotalW'(dyn_rdata_i.waiting);
          tt_q <= tt_q + TotalW'(turn_full);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/srtf_outreg.sv =====
// Result output register with valid/ready handshake.
// Depends on srtf_pkg; loaded by the sequencer.
`default_nettype none

module srtf_outreg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire srtf_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output srtf_pkg::result_t      res_o
);

  logic              valid_q;
  srtf_pkg::result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srtf_waiting_times_core.sv =====
// SRTF waiting-time block, top level.
// Instantiates srtf_seq, srtf_mem and srtf_outreg; depends on srtf_pkg.
//
// Input channel (in_valid_i/in_ready_o) takes one process transaction per
// cycle while the block is loading: arrival and burst time, and a final flag.
// Non-final transactions produce no result. The final transaction starts the
// simulation; in_ready_o stays low until the last result has been loaded.
// The simulation runs in passes over the process table memory: each pass
// reads all n stored entries and is followed by a decide state and, when
// a process completes, a retire state. The number of passes is at most
// about 2n + 1 (every completion and every arrival ends a pass). Results
// then come out in index order on out_valid_o/out_ready_i; each is read
// from memory and then loaded when the output register is free.
// A stalled receiver holds the output register and the sequencer waits.
// Once the final result sits in the output register, the block accepts the
// next run's entries. Entries beyond MAX_PROCESSES are dropped and flagged.
// Reset clears all counters and the output valid; table contents are
// written before they are read and need no clearing.
`default_nettype none

module srtf_waiting_times_core #(
  parameter int MAX_PROCESSES = srtf_pkg::MaxProcessesDef,
  parameter int TIME_BITS     = srtf_pkg::TimeBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [srtf_pkg::TimeW-1:0]      arrival_time_i,
  input  wire logic [srtf_pkg::TimeW-1:0]      burst_time_i,
  input  wire logic                            final_entry_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [srtf_pkg::PnumW-1:0]           process_number_o,
  output logic [srtf_pkg::WaitW-1:0]           waiting_time_o,
  output logic [srtf_pkg::WaitW-1:0]           turnaround_o,
  output logic [srtf_pkg::TotalW-1:0]          total_waiting_o,
  output logic [srtf_pkg::TotalW-1:0]          total_turnaround_o,
  output logic                                 overflow_o,
  output logic                                 final_result_o
);

  localparam int IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CntW = $clog2(MAX_PROCESSES + 1);

  srtf_pkg::mem_ctl_t  mem_ctl;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  srtf_pkg::tbl_word_t tbl_wdata, tbl_rdata;
  srtf_pkg::dyn_word_t dyn_wdata, dyn_rdata;
  logic                res_free, res_load;
  srtf_pkg::result_t   res_next, res_out;

  srtf_seq #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .TIME_BITS    (TIME_BITS),
    .IdxW         (IdxW),
    .CntW         (CntW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .arrival_time_i(arrival_time_i),
    .burst_time_i  (burst_time_i),
    .final_entry_i (final_entry_i),
    .mem_ctl_o     (mem_ctl),
    .mem_waddr_o   (mem_waddr),
    .tbl_wdata_o   (tbl_wdata),
    .dyn_wdata_o   (dyn_wdata),
    .mem_raddr_o   (mem_raddr),
    .tbl_rdata_i   (tbl_rdata),
    .dyn_rdata_i   (dyn_rdata),
    .res_free_i    (res_free),
    .res_load_o    (res_load),
    .res_o         (res_next)
  );

  srtf_mem #(
    .Depth(MAX_PROCESSES),
    .IdxW (IdxW)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .waddr_i    (mem_waddr),
    .tbl_wdata_i(tbl_wdata),
    .dyn_wdata_i(dyn_wdata),
    .raddr_i    (mem_raddr),
    .tbl_rdata_o(tbl_rdata),
    .dyn_rdata_o(dyn_rdata)
  );

  srtf_outreg u_outreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_load),
    .res_i      (res_next),
    .free_o     (res_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign process_number_o   = res_out.process_number;
  assign waiting_time_o     = res_out.waiting_time;
  assign turnaround_o       = res_out.turnaround;
  assign total_waiting_o    = res_out.total_waiting;
  assign total_turnaround_o = res_out.total_turnaround;
  assign overflow_o         = res_out.overflow;
  assign final_result_o     = res_out.final_result;

endmodule

`default_nettype wire

// ===== hdl/srtf_checker.sv =====
// Port-level checker for srtf_waiting_times_core, attached by bind.
// Depends on srtf_pkg for field widths.
`default_nettype none

module srtf_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            final_entry_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [srtf_pkg::PnumW-1:0]      process_number_o,
  input wire logic [srtf_pkg::WaitW-1:0]      waiting_time_o,
  input wire logic [srtf_pkg::TotalW-1:0]     total_waiting_o,
  input wire logic [srtf_pkg::TotalW-1:0]     total_turnaround_o,
  input wire logic                            final_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(process_number_o) &&
                                    $stable(waiting_time_o))
    else $error("result changed while stalled");

  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_result_o |-> !in_ready_o)
    else $error("input ready while a run is still reporting");

  a_totals_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_result_o |-> total_waiting_o == '0 && total_turnaround_o == '0)
    else $error("totals shown on a non-final result");

  a_final_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_entry_i |=> !in_ready_o)
    else $error("input still ready after the final transaction");

endmodule

bind srtf_waiting_times_core srtf_checker u_srtf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .final_entry_i     (final_entry_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .process_number_o  (process_number_o),
  .waiting_time_o    (waiting_time_o),
  .total_waiting_o   (total_waiting_o),
  .total_turnaround_o(total_turnaround_o),
  .final_result_o    (final_result_o)
);

`default_nettype wire

// ===== tb/srtf_checker.sv =====
// Scoreboard for srtf_waiting_times_core: watches both channels and predicts per-process results.
// It replays shortest-remaining-time-first scheduling on the captured table and compares
// every result transaction field by field. Depends on srtf_pkg.
module srtf_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [srtf_pkg::TimeW-1:0]    arrival_time_i,
  input  logic [srtf_pkg::TimeW-1:0]    burst_time_i,
  input  logic                          final_entry_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [srtf_pkg::PnumW-1:0]    process_number_o,
  input  logic [srtf_pkg::WaitW-1:0]    waiting_time_o,
  input  logic [srtf_pkg::WaitW-1:0]    turnaround_o,
  input  logic [srtf_pkg::TotalW-1:0]   total_waiting_o,
  input  logic [srtf_pkg::TotalW-1:0]   total_turnaround_o,
  input  logic                          overflow_o,
  input  logic                          final_result_o,
  output int                            mismatch_count_o,
  output int                            pending_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = srtf_pkg::MaxProcessesDef;
  localparam logic [63:0] NoTime = '1;

  logic [srtf_pkg::TimeW-1:0] arrival_tab [srtf_pkg::SlotLimit];
  logic [srtf_pkg::TimeW-1:0] burst_tab [srtf_pkg::SlotLimit];
  int                         stored_count;
  bit                         dropped_seen;
  srtf_pkg::result_t          expected_results [$];
  srtf_pkg::result_t          want;
  int                         error_count;

  function automatic void schedule_run();
    logic [63:0]       remaining [srtf_pkg::SlotLimit];
    logic [63:0]       waited [srtf_pkg::SlotLimit];
    logic [63:0]       now, best, next_arrival, run, used, turn, sum_wait, sum_turn;
    int                done, chosen, n;
    bit                running;
    srtf_pkg::result_t res;
    n = stored_count;
    done = 0;
    for (int j = 0; j < n; j++) begin
      remaining[j] = burst_tab[j];
      waited[j] = 0;
      if (burst_tab[j] == 0) done++;
    end
    now = 0;
    running = 0;
    chosen = 0;
    while (done < n) begin
      best = running ? remaining[chosen] : NoTime;
      next_arrival = NoTime;
      for (int j = 0; j < n; j++) begin
        if (remaining[j] != 0 && arrival_tab[j] <= now && remaining[j] < best) begin
          best = remaining[j];
          chosen = j;
          running = 1;
        end
      end
      for (int j = 0; j < n; j++) begin
        if (remaining[j] != 0 && arrival_tab[j] > now && arrival_tab[j] < next_arrival)
          next_arrival = arrival_tab[j];
      end
      if (!running) begin
        if (next_arrival == NoTime) break;
        now = next_arrival;
        continue;
      end
      run = remaining[chosen];
      if (next_arrival != NoTime && next_arrival - now < run) run = next_arrival - now;
      remaining[chosen] -= run;
      now += run;
      if (remaining[chosen] == 0) begin
        used = 64'(burst_tab[chosen]) + 64'(arrival_tab[chosen]);
        waited[chosen] = (now > used) ? now - used : 64'd0;
        done++;
        running = 0;
      end
    end
    sum_wait = 0;
    sum_turn = 0;
    for (int i = 0; i < n; i++) begin
      turn = 64'(burst_tab[i]) + waited[i];
      sum_wait += waited[i];
      sum_turn += turn;
      res.process_number   = srtf_pkg::PnumW'(i + 1);
      res.waiting_time     = waited[i][srtf_pkg::WaitW-1:0];
      res.turnaround       = turn[srtf_pkg::WaitW-1:0];
      res.total_waiting    = (i == n - 1) ? sum_wait[srtf_pkg::TotalW-1:0] : '0;
      res.total_turnaround = (i == n - 1) ? sum_turn[srtf_pkg::TotalW-1:0] : '0;
      res.overflow         = dropped_seen;
      res.final_result     = (i == n - 1);
      expected_results.push_back(res);
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      if (error_count < 10)
        $display("%0t: %s mismatch on process %0d: expected %0d, got %0d",
                 $realtime, name, want.process_number, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      dropped_seen = 0;
      error_count = 0;
      expected_results.delete();
      pending_results_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (stored_count < Capacity) begin
          arrival_tab[stored_count] = arrival_time_i;
          burst_tab[stored_count] = burst_time_i;
          stored_count++;
        end else begin
          dropped_seen = 1;
        end
        if (final_entry_i) begin
          schedule_run();
          stored_count = 0;
          dropped_seen = 0;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected result transaction for process %0d",
                     $realtime, process_number_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("process_number", want.process_number, process_number_o);
          compare_field("waiting_time", want.waiting_time, waiting_time_o);
          compare_field("turnaround", want.turnaround, turnaround_o);
          compare_field("total_waiting", want.total_waiting, total_waiting_o);
          compare_field("total_turnaround", want.total_turnaround, total_turnaround_o);
          compare_field("overflow", want.overflow, overflow_o);
          compare_field("final_result", want.final_result, final_result_o);
        end
      end
      pending_results_o <= expected_results.size();
      mismatch_count_o <= error_count;
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the srtf_waiting_times_core testbench: clock, reset, process stimulus and verdict.
// Drives process transactions with random gaps and stalls the result channel at random;
// srtf_scoreboard does the prediction and comparison. Depends on srtf_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [srtf_pkg::TimeW-1:0]  arrival_time_i = '0;
  logic [srtf_pkg::TimeW-1:0]  burst_time_i = '0;
  logic                        final_entry_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [srtf_pkg::PnumW-1:0]  process_number_o;
  logic [srtf_pkg::WaitW-1:0]  waiting_time_o;
  logic [srtf_pkg::WaitW-1:0]  turnaround_o;
  logic [srtf_pkg::TotalW-1:0] total_waiting_o;
  logic [srtf_pkg::TotalW-1:0] total_turnaround_o;
  logic                        overflow_o;
  logic                        final_result_o;

  int mismatches;
  int pending_results;
  int accepted_items = 0;
  bit steady_feed = 0;

  always #6 clk_i = ~clk_i;

  srtf_waiting_times_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .final_entry_i      (final_entry_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .process_number_o   (process_number_o),
    .waiting_time_o     (waiting_time_o),
    .turnaround_o       (turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .overflow_o         (overflow_o),
    .final_result_o     (final_result_o)
  );

  srtf_scoreboard u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .final_entry_i      (final_entry_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .process_number_o   (process_number_o),
    .waiting_time_o     (waiting_time_o),
    .turnaround_o       (turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .overflow_o         (overflow_o),
    .final_result_o     (final_result_o),
    .mismatch_count_o   (mismatches),
    .pending_results_o  (pending_results)
  );

  function automatic int idle_gap(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [srtf_pkg::TimeW-1:0] pick_time(input int span);
    case (span)
      0:       return srtf_pkg::TimeW'($urandom_range(0, 15));
      1:       return srtf_pkg::TimeW'($urandom_range(0, 255));
      default: return srtf_pkg::TimeW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_process(input logic [srtf_pkg::TimeW-1:0] arrival,
                              input logic [srtf_pkg::TimeW-1:0] burst,
                              input logic last);
    int gap;
    gap = idle_gap(steady_feed);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    arrival_time_i <= arrival;
    burst_time_i <= burst;
    final_entry_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    accepted_items++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic random_run(input int size, input int arrival_span, input int burst_span);
    logic [srtf_pkg::TimeW-1:0] burst;
    for (int k = 0; k < size; k++) begin
      burst = ($urandom_range(0, 9) == 0) ? '0 : pick_time(burst_span);
      send_process(pick_time(arrival_span), burst, k == size - 1);
    end
  endtask

  initial begin
    int stall;
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_gap(1'b0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk_i);
    end
  end

  initial begin
    #4800000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int run_index;
    int size;
    int wait_cycles;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_process(16'h0000, 16'h0000, 1'b1);
    send_process(16'hFFFF, 16'hFFFF, 1'b1);
    send_process(16'd5, 16'd4, 1'b0);
    send_process(16'd0, 16'd8, 1'b0);
    send_process(16'd1, 16'd3, 1'b0);
    send_process(16'd1, 16'd3, 1'b0);
    send_process(16'd3, 16'd0, 1'b0);
    send_process(16'd40, 16'd2, 1'b1);
    send_process(16'd0, 16'd6, 1'b0);
    send_process(16'd1, 16'd5, 1'b0);
    send_process(16'd2, 16'd5, 1'b1);
    send_process(16'hFFFF, 16'd1, 1'b0);
    send_process(16'd0, 16'hFFFF, 1'b0);
    send_process(16'h8000, 16'h7FFF, 1'b1);
    send_process(16'hAAAA, 16'h5555, 1'b0);
    send_process(16'h5555, 16'hAAAA, 1'b1);
    drain_results();

    run_index = 0;
    while (accepted_items < 170) begin
      steady_feed = ($urandom_range(0, 3) == 0);
      if (run_index == 3) begin
        random_run(66, 1, 0);
      end else begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        random_run(size, $urandom_range(0, 2), $urandom_range(0, 2));
      end
      if ($urandom_range(0, 4) == 0) drain_results();
      run_index++;
    end

    in_valid_i <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk_i);
      wait_cycles++;
    end while (pending_results != 0 && wait_cycles < 100000);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
